// ===== rtl/rog_pkg.sv =====
package rog_pkg;

  localparam int W      = 32;
  localparam int FRAC   = 16;
  localparam int QW     = W + FRAC;
  localparam int ACC_W  = 50;
  localparam int SUM_W  = 52;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;

  localparam logic [2:0] MUL_STEPS = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NUM,
    S_DIV1,
    S_DIV2,
    S_UPD,
    S_FIN
  } rog_state_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(MAXV);
    lo = SUM_W'(MINV);
    if (x > hi) return MAXV;
    else if (x < lo) return MINV;
    else return x[W-1:0];
  endfunction

endpackage

// ===== rtl/rog_in_if.sv =====
interface rog_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic signed [31:0] box_center;
  logic        [30:0] box_size;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  logic               last_axis;

  modport source (
    output valid, axis_x, axis_y, axis_z, box_center, box_size,
           trans_x, trans_y, trans_z, last_axis,
    input  ready
  );
  modport sink (
    input  valid, axis_x, axis_y, axis_z, box_center, box_size,
           trans_x, trans_y, trans_z, last_axis,
    output ready
  );
endinterface

// ===== rtl/rog_out_if.sv =====
interface rog_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;
  logic        degenerate;

  modport source (output valid, hit, distance, degenerate, input ready);
  modport sink   (input valid, hit, distance, degenerate, output ready);
endinterface

// ===== rtl/ray_obb_slab_test.sv =====
// Channel   Dir  Word
// items     in   one box axis: axis, centre, size, translation, last_axis
// results   out  hit, distance, degenerate; one word per box (on last_axis)
// cfg_*     in   ray origin and direction registers, write only
//
// Each axis forms six products on the one shared 32x32 multiplier, then,
// unless the projected direction is zero or the box is already missed,
// two runs of the bit-serial divider. One axis is worked on at a time.
// Synchronous reset clears sequencer, slab state, valid, origin; dir to +X.
// A waiting result word stalls only the final step of the next box.
module ray_obb_slab_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rog_in_if.sink      items,
  rog_out_if.source   results
);
  import rog_pkg::*;

  // configuration
  logic signed [W-1:0] org_x, org_y, org_z;
  logic signed [W-1:0] dir_x, dir_y, dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      dir_x <= W'(32'sd65536);
      dir_y <= '0;
      dir_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORG_X: org_x <= cfg_data;
        REG_ORG_Y: org_y <= cfg_data;
        REG_ORG_Z: org_z <= cfg_data;
        REG_DIR_X: dir_x <= cfg_data;
        REG_DIR_Y: dir_y <= cfg_data;
        REG_DIR_Z: dir_z <= cfg_data;
        default: ;
      endcase
    end
  end

  rog_state_t state, state_next;

  // latched axis word; deltas saturated on capture
  logic signed [W-1:0] ax, ay, az, centre;
  logic signed [W-1:0] dx, dy, dz;
  logic        [30:0]  bsize;
  logic                last;

  logic accept;
  assign accept = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      ax     <= items.axis_x;
      ay     <= items.axis_y;
      az     <= items.axis_z;
      centre <= items.box_center;
      bsize  <= items.box_size;
      last   <= items.last_axis;
      dx     <= sat_w(SUM_W'(items.trans_x) - SUM_W'(org_x));
      dy     <= sat_w(SUM_W'(items.trans_y) - SUM_W'(org_y));
      dz     <= sat_w(SUM_W'(items.trans_z) - SUM_W'(org_z));
    end
  end

  // shared multiplier: step k multiplies, step k+1 accumulates
  logic [2:0]              cnt;
  logic signed [W-1:0]     op_a, op_b;
  logic signed [2*W-1:0]   prod;
  logic signed [QW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_e, acc_f;
  logic [2:0]              acc_idx;

  always_comb begin
    unique case (cnt)
      3'd0:    begin op_a = ax;    op_b = dx; end
      3'd1:    begin op_a = ay;    op_b = dy; end
      3'd2:    begin op_a = az;    op_b = dz; end
      3'd3:    begin op_a = dir_x; op_b = ax; end
      3'd4:    begin op_a = dir_y; op_b = ay; end
      default: begin op_a = dir_z; op_b = az; end
    endcase
  end

  assign prod    = op_a * op_b;
  assign acc_idx = cnt - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == S_MUL) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_e <= '0;
      acc_f <= '0;
    end else if (state == S_MUL) begin
      prod_q <= prod[2*W-1:FRAC];
      if (cnt != 3'd0) begin
        if (acc_idx < 3'd3) acc_e <= acc_e + ACC_W'(prod_q);
        else                acc_f <= acc_f + ACC_W'(prod_q);
      end
    end
  end

  // numerators and projected direction
  logic signed [W-1:0]     f_sat, f_q;
  logic signed [SUM_W-1:0] half, base;
  logic signed [W-1:0]     n1, n2, n2_q;
  logic                    f_zero;

  assign f_sat  = sat_w(SUM_W'(acc_f));
  assign f_zero = (f_sat == '0);
  assign half   = SUM_W'({1'b0, bsize[30:1]});
  assign base   = SUM_W'(acc_e) + SUM_W'(centre);
  assign n1     = sat_w(base - half);
  assign n2     = sat_w(base + half);

  // divider; the first run starts before f_q is loaded, so it takes f_sat
  logic                div_start, div_done;
  logic signed [W-1:0] div_num, div_den, div_quo, t1_q;

  rog_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // slab state
  logic signed [W-1:0] near_t, far_t;
  logic                missed, zero_seen;
  logic signed [W-1:0] lo, hi, nn, nf;
  logic                out_free;

  assign lo       = (t1_q > div_quo) ? div_quo : t1_q;
  assign hi       = (t1_q > div_quo) ? t1_q : div_quo;
  assign nf       = (hi < far_t) ? hi : far_t;
  assign nn       = (lo > near_t) ? lo : near_t;
  assign out_free = !results.valid || results.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MUL;
      S_MUL:  if (cnt == MUL_STEPS) state_next = S_NUM;
      S_NUM:  state_next = (f_zero || missed) ? S_FIN : S_DIV1;
      S_DIV1: if (div_done) state_next = S_DIV2;
      S_DIV2: if (div_done) state_next = S_FIN;
      S_UPD:  state_next = S_FIN;
      S_FIN:  if (!last || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    items.ready = (state == S_IDLE);
    div_start   = 1'b0;
    div_num     = n2_q;
    div_den     = f_q;
    unique case (state)
      S_NUM: begin
        div_start = !f_zero && !missed;
        div_num   = n1;
        div_den   = f_sat;
      end
      S_DIV1: div_start = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_NUM) begin
      f_q  <= f_sat;
      n2_q <= n2;
    end
    if (state == S_DIV1 && div_done) t1_q <= div_quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_t    <= '0;
      far_t     <= MAXV;
      missed    <= 1'b0;
      zero_seen <= 1'b0;
    end else begin
      if (state == S_NUM && f_zero) begin
        missed    <= 1'b1;
        zero_seen <= 1'b1;
      end
      if (state == S_DIV2 && div_done) begin
        near_t <= nn;
        far_t  <= nf;
        if (nf < nn) missed <= 1'b1;
      end
      if (state == S_FIN && last && out_free) begin
        near_t    <= '0;
        far_t     <= MAXV;
        missed    <= 1'b0;
        zero_seen <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_FIN && last && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && last && out_free) begin
      results.hit        <= !missed;
      results.distance   <= missed ? '0 : near_t[30:0];
      results.degenerate <= zero_seen;
    end
  end

`ifndef ASSERT_OFF
  a_slab_order: assert property (@(posedge clk) disable iff (rst)
    !missed |-> near_t <= far_t)
    else $error("slab interval inverted without miss");

  a_near_nonneg: assert property (@(posedge clk) disable iff (rst)
    !near_t[W-1])
    else $error("near parameter negative");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a divide step");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == S_FIN && $past(last))
    else $error("result word raised outside final step");
`endif

endmodule

// ===== rtl/rog_div.sv =====
// Signed fixed-point divider, one quotient bit a cycle, saturating result.
module rog_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic        done,
  output logic signed [31:0] quo
);
  import rog_pkg::*;

  logic          busy;
  logic [5:0]    cnt;
  logic [QW-1:0] q;
  logic [W-1:0]  rem;
  logic [W-1:0]  dmag;
  logic          neg;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  nmag;

  assign nmag   = num[W-1] ? W'(-num) : W'(num);
  assign rem_sh = {rem, q[QW-1]};
  assign diff   = rem_sh - {1'b0, dmag};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'(QW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= {nmag, {FRAC{1'b0}}};
      rem  <= '0;
      dmag <= den[W-1] ? W'(-den) : W'(den);
      neg  <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      q   <= {q[QW-2:0], ge};
    end
  end

  // saturate magnitude back to signed range
  always_comb begin
    if (!neg) begin
      quo = (|q[QW-1:W-1]) ? MAXV : {1'b0, q[W-2:0]};
    end else begin
      quo = (q > QW'({1'b1, {(W-1){1'b0}}})) ? MINV : W'(-q[W-1:0]);
    end
  end

endmodule
